### rtl/lsvp_pkg.sv
package lsvp_pkg;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_THIRD  = 3'd3,
        OP_BOTTOM = 3'd4,
        OP_PURGE  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_SHORT    = 2'd3
    } t_status;

    // How a cell loads: keep, take the word above it (push),
    // or take the word below it (pop and purge step).
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_DOWN = 2'd1,
        SH_UP   = 2'd2
    } t_shift;

    typedef struct packed {
        t_shift mode;
        logic   append;
    } t_cell_ctrl;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_PURGE = 1'b1
    } t_state;

    localparam logic [31:0] FAIL_WORD = 32'h7FFF_FFFF;
    localparam int          THIRD_MIN = 3;

endpackage

### rtl/lsvp_cell.sv
module lsvp_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 3
) (
    input  logic                i_clk,
    input  lsvp_pkg::t_cell_ctrl i_ctrl,
    input  logic [IW-1:0]       i_pos,
    input  logic [31:0]         i_above,
    input  logic [31:0]         i_below,
    input  logic [31:0]         i_top_word,
    output logic [31:0]         o_value
);
    import lsvp_pkg::*;

    localparam logic [IW-1:0] MY_POS = IW'(INDEX);

    logic [31:0] r_value;

    // During a purge step the kept top word is placed at the cell that
    // becomes the bottom of the live entries.
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.mode)
            SH_HOLD: begin
                r_value <= r_value;
            end
            SH_DOWN: begin
                r_value <= i_above;
            end
            SH_UP: begin
                if (i_ctrl.append && (i_pos == MY_POS)) begin
                    r_value <= i_top_word;
                end else begin
                    r_value <= i_below;
                end
            end
            default: begin
                r_value <= r_value;
            end
        endcase
    end

    assign o_value = r_value;

endmodule

### rtl/lifo_stack_with_value_purge.sv
// LIFO stack of signed 32-bit words, DEPTH entries deep, built as a row of
// cells with the top of the stack in cell 0. Each request beat carries an
// operation in tuser and an operand word in tdata, and gives exactly one
// result beat with the read data, a status and the entry count after the
// request. Push, pop, peek, third-from-top and bottom are accepted at one
// beat per cycle while the result beats are taken: the row shifts down or up
// by one cell and the result sits in an output register. Purge walks the
// live entries one per cycle by popping the top and, when it differs from
// the purge value, re-inserting it at the bottom of the live region. The
// result of a purge is registered at the end of the walk (at once when the
// stack is empty), and no new request is taken during the walk. Failures
// return 2147483647 as data. Entry storage has no reset; only the entry
// count and the control are cleared.
module lifo_stack_with_value_purge #(
    parameter int DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] operand_value
    input  logic [2:0]  i_s_axis_tuser,  // [2:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [31:0] read_data, [35:32] entry_count, rest 0
    output logic [1:0]  o_m_axis_tuser   // [1:0] status
);
    import lsvp_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    logic [31:0] r_victim, n_victim;
    logic [31:0] r_bottom, n_bottom;

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_rd, n_rd;
    t_status     r_status, n_status;
    logic [CW-1:0] r_cnt_out, n_cnt_out;

    t_cell_ctrl  w_ctrl;
    logic [IW-1:0] w_pos;
    logic [31:0] w_value [DEPTH];
    logic        w_accept;
    logic        w_keep;
    logic [2:0]  w_op;
    logic [31:0] w_word;
    logic [CW+3:0] w_cnt_ext;

    assign w_op   = i_s_axis_tuser;
    assign w_word = i_s_axis_tdata;

    // A new request is taken only between purges and when the output
    // register is free or is being emptied in this cycle.
    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // The top word survives a purge step when it differs from the value.
    assign w_keep = (w_value[0] != r_victim);

    // The row of cells. Cell 0 is the top; a push feeds the operand into it.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [31:0] w_above;
        logic [31:0] w_below;
        if (i == 0) begin : g_first
            assign w_above = w_word;
        end else begin : g_mid
            assign w_above = w_value[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_below = w_value[i];
        end else begin : g_inner
            assign w_below = w_value[i+1];
        end
        lsvp_cell #(
            .INDEX (i),
            .IW    (IW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_pos      (w_pos),
            .i_above    (w_above),
            .i_below    (w_below),
            .i_top_word (w_value[0]),
            .o_value    (w_value[i])
        );
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_op == OP_PURGE) && (r_count != '0)) begin
                    n_state = ST_PURGE;
                end
            end
            ST_PURGE: begin
                if (r_left == ONE) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and result logic.
    always_comb begin
        w_ctrl      = '{mode: SH_HOLD, append: 1'b0};
        w_pos       = '0;
        n_count     = r_count;
        n_left      = r_left;
        n_victim    = r_victim;
        n_bottom    = r_bottom;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_rd        = r_rd;
        n_status    = r_status;
        n_cnt_out   = r_cnt_out;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_rd        = '0;
                    n_status    = STAT_OK;
                    n_cnt_out   = r_count;
                    unique case (w_op)
                        OP_PUSH: begin
                            if (r_count == FULL) begin
                                n_rd     = FAIL_WORD;
                                n_status = STAT_OVERFLOW;
                            end else begin
                                w_ctrl.mode = SH_DOWN;
                                n_count     = r_count + ONE;
                                n_cnt_out   = r_count + ONE;
                                if (r_count == '0) begin
                                    n_bottom = w_word;
                                end
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_rd     = FAIL_WORD;
                                n_status = STAT_EMPTY;
                            end else begin
                                w_ctrl.mode = SH_UP;
                                n_rd        = w_value[0];
                                n_count     = r_count - ONE;
                                n_cnt_out   = r_count - ONE;
                            end
                        end
                        OP_PEEK: begin
                            if (r_count == '0) begin
                                n_rd     = FAIL_WORD;
                                n_status = STAT_EMPTY;
                            end else begin
                                n_rd = w_value[0];
                            end
                        end
                        OP_THIRD: begin
                            if (r_count < CW'(THIRD_MIN)) begin
                                n_rd     = FAIL_WORD;
                                n_status = STAT_SHORT;
                            end else begin
                                n_rd = w_value[2];
                            end
                        end
                        OP_BOTTOM: begin
                            if (r_count == '0) begin
                                n_rd     = FAIL_WORD;
                                n_status = STAT_EMPTY;
                            end else begin
                                n_rd = r_bottom;
                            end
                        end
                        OP_PURGE: begin
                            // An empty stack answers at once; otherwise the
                            // result waits for the end of the walk.
                            if (r_count != '0) begin
                                n_out_valid = 1'b0;
                                n_left      = r_count;
                                n_victim    = w_word;
                            end
                        end
                        default: begin
                            n_rd = '0;
                        end
                    endcase
                end
            end
            ST_PURGE: begin
                // Pop the top; a kept word goes to the last live cell, which
                // after the shift sits at r_count - 1.
                w_ctrl.mode   = SH_UP;
                w_ctrl.append = w_keep;
                w_pos         = IW'(r_count - ONE);
                n_left        = r_left - ONE;
                if (w_keep) begin
                    n_bottom = w_value[0];
                end else begin
                    n_count = r_count - ONE;
                end
                if (r_left == ONE) begin
                    n_out_valid = 1'b1;
                    n_rd        = '0;
                    n_status    = STAT_OK;
                    n_cnt_out   = w_keep ? r_count : r_count - ONE;
                end
            end
            default: begin
                w_ctrl.mode = SH_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_victim  <= n_victim;
        r_bottom  <= n_bottom;
        r_rd      <= n_rd;
        r_status  <= n_status;
        r_cnt_out <= n_cnt_out;
    end

    // The count field is four bits wide whatever the depth.
    assign w_cnt_ext       = {4'b0000, r_cnt_out};
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, w_cnt_ext[3:0], r_rd};
    assign o_m_axis_tuser  = r_status;

    // The stack never holds more than DEPTH entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count above depth");

    // No request is taken while a purge walks the entries.
    a_purge_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PURGE) |-> !o_s_axis_tready)
        else $error("request accepted during purge");

    // A purge step can only drop entries.
    a_purge_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PURGE) |=> (r_count <= $past(r_count)))
        else $error("purge step raised the count");

    // Any accepted request other than purge has its result in the next cycle.
    a_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op != OP_PURGE)) |=> o_m_axis_tvalid)
        else $error("result missing after a single-cycle request");

    // The walk length never exceeds the count it started from.
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PURGE) |-> ((r_left != '0) && (r_left <= r_count)))
        else $error("purge walk length out of range");

endmodule
